// File: rtl/core/amu_pkg.sv
// ---------------------------------------------------------------------------
// amu_pkg: shared types and constants of the atomic memory unit
// Holds the memory geometry, the action codes and the ALU result record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package amu_pkg;

    // Memory geometry.
    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 10;
    localparam int SIZE_W  = 11;

    // Configuration register and its reset value.
    localparam logic [SIZE_W-1:0] WORDS_RESET = SIZE_W'(1024);
    localparam int                PADDR_W     = 3;
    localparam logic [PADDR_W-1:0] ADDR_WORDS_IN_USE = 3'd0;

    // Action codes of a transaction.
    typedef enum logic [3:0] {
        ACT_LOAD    = 4'd0,
        ACT_STORE   = 4'd1,
        ACT_ADD     = 4'd2,
        ACT_SUB     = 4'd3,
        ACT_MAX     = 4'd4,
        ACT_MIN     = 4'd5,
        ACT_AND     = 4'd6,
        ACT_OR      = 4'd7,
        ACT_XOR     = 4'd8,
        ACT_XCHG    = 4'd9,
        ACT_CMPXCHG = 4'd10
    } action_t;

    // Outcome of one read-modify-write.
    typedef struct packed {
        logic [WORD_W-1:0] next_word;
        logic [WORD_W-1:0] ret_word;
        logic              xchg;
    } alu_result_t;

endpackage

// File: rtl/core/atomic_memory_unit.sv
// ---------------------------------------------------------------------------
// atomic_memory_unit: word memory serving atomic read-modify-write requests
// Requests pass a read stage (s2) and then the output register. Throughput: one
// transaction per cycle while the result channel does not stall, set by the single
// RAM read and write port; back-to-back requests to one word use a forwarding register.
// Reset: a clearing pass writes zero to all 1024 words, one a cycle, and no
// request is accepted while it runs; configuration writes are taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module atomic_memory_unit (
    input  logic                              clk,
    input  logic                              rst_n,

    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [amu_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,

    // Request channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [3:0]                        action,
    input  logic                              is_signed,
    input  logic [amu_pkg::INDEX_W-1:0]       word_index,
    input  logic [amu_pkg::WORD_W-1:0]        operand_value,
    input  logic [amu_pkg::WORD_W-1:0]        compare_value,

    // Result channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [amu_pkg::WORD_W-1:0]        prior_value,
    output logic                              exchanged,
    output logic                              out_of_bounds
);

    // Configuration register.
    logic [amu_pkg::SIZE_W-1:0] words_in_use_reg;
    logic                       cfg_write;

    // Clearing pass.
    logic                       clearing_reg;
    logic [amu_pkg::ADDR_W-1:0] clr_addr_reg;

    // Read stage: request whose RAM data arrives this cycle.
    logic                       s2_valid_reg;
    logic [3:0]                 s2_action_reg;
    logic                       s2_signed_reg;
    logic [amu_pkg::ADDR_W-1:0] s2_index_reg;
    logic [amu_pkg::WORD_W-1:0] s2_opv_reg;
    logic [amu_pkg::WORD_W-1:0] s2_cmpv_reg;
    logic                       s2_oob_reg;

    // Forwarding of the last write.
    logic                       fwd_valid_reg;
    logic [amu_pkg::ADDR_W-1:0] fwd_index_reg;
    logic [amu_pkg::WORD_W-1:0] fwd_data_reg;

    // Output register.
    logic                       out_valid_reg;
    logic [amu_pkg::WORD_W-1:0] out_old_reg;
    logic                       out_xchg_reg;
    logic                       out_oob_reg;

    logic                       accept;
    logic                       s2_advance;
    logic                       can_advance;
    logic                       req_oob;
    logic                       upd_write;
    logic [amu_pkg::WORD_W-1:0] ram_rdata;
    logic [amu_pkg::WORD_W-1:0] old_word;
    logic                       ram_we;
    logic [amu_pkg::ADDR_W-1:0] ram_waddr;
    logic [amu_pkg::WORD_W-1:0] ram_wdata;
    amu_pkg::alu_result_t       alu_res;

    // Configuration port access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == amu_pkg::ADDR_WORDS_IN_USE);
    assign prdata    = (paddr == amu_pkg::ADDR_WORDS_IN_USE)
                       ? {{(32-amu_pkg::SIZE_W){1'b0}}, words_in_use_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_in_use_reg <= amu_pkg::WORDS_RESET;
        end
        else if (cfg_write)
        begin
            words_in_use_reg <= pwdata[amu_pkg::SIZE_W-1:0];
        end
    end

    // Handshake and stage control.
    assign can_advance = !out_valid_reg || !out_stall;
    assign s2_advance  = s2_valid_reg && can_advance;
    assign in_stall    = clearing_reg || (s2_valid_reg && !can_advance);
    assign accept      = in_valid && !in_stall;
    assign req_oob     = {1'b0, word_index} >= words_in_use_reg;

    // Clearing pass after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == amu_pkg::ADDR_W'(amu_pkg::DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Read stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_advance)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_action_reg <= action;
            s2_signed_reg <= is_signed;
            s2_index_reg  <= word_index;
            s2_opv_reg    <= operand_value;
            s2_cmpv_reg   <= compare_value;
            s2_oob_reg    <= req_oob;
        end
    end

    // The word memory.
    amu_ram #(
        .WIDTH (amu_pkg::WORD_W),
        .DEPTH (amu_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (word_index),
        .rdata (ram_rdata)
    );

    // A write at the edge of the read returns stale data; take the forwarded word.
    assign old_word = (fwd_valid_reg && (fwd_index_reg == s2_index_reg))
                      ? fwd_data_reg : ram_rdata;

    amu_alu u_alu (
        .action        (amu_pkg::action_t'(s2_action_reg)),
        .is_signed     (s2_signed_reg),
        .old_word      (old_word),
        .operand_value (s2_opv_reg),
        .compare_value (s2_cmpv_reg),
        .result        (alu_res)
    );

    // Write back: the clearing pass owns the port until it ends.
    assign upd_write = s2_advance && !s2_oob_reg;
    assign ram_we    = clearing_reg || upd_write;
    assign ram_waddr = clearing_reg ? clr_addr_reg : s2_index_reg;
    assign ram_wdata = clearing_reg ? '0 : alu_res.next_word;

    // Forwarding register tracks the latest update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (upd_write)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_write)
        begin
            fwd_index_reg <= s2_index_reg;
            fwd_data_reg  <= alu_res.next_word;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_advance)
        begin
            out_old_reg  <= s2_oob_reg ? '0 : alu_res.ret_word;
            out_xchg_reg <= s2_oob_reg ? 1'b0 : alu_res.xchg;
            out_oob_reg  <= s2_oob_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign prior_value   = out_old_reg;
    assign exchanged     = out_xchg_reg;
    assign out_of_bounds = out_oob_reg;

endmodule

// File: rtl/core/amu_ram.sv
// ---------------------------------------------------------------------------
// amu_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old content.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module amu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/amu_alu.sv
// ---------------------------------------------------------------------------
// amu_alu: atomic operation datapath
// Combines the old word with the operands and gives the word to write back,
// the word to return and the compare-exchange flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module amu_alu (
    input  amu_pkg::action_t                action,
    input  logic                            is_signed,
    input  logic [amu_pkg::WORD_W-1:0]      old_word,
    input  logic [amu_pkg::WORD_W-1:0]      operand_value,
    input  logic [amu_pkg::WORD_W-1:0]      compare_value,
    output amu_pkg::alu_result_t            result
);

    logic [amu_pkg::WORD_W-1:0] sign_flip;
    logic [amu_pkg::WORD_W-1:0] old_key;
    logic [amu_pkg::WORD_W-1:0] opv_key;
    logic                       old_below;
    logic                       opv_below;

    // Flipping the sign bit maps signed order onto unsigned order.
    assign sign_flip = {is_signed, {(amu_pkg::WORD_W-1){1'b0}}};
    assign old_key   = old_word ^ sign_flip;
    assign opv_key   = operand_value ^ sign_flip;
    assign old_below = old_key < opv_key;
    assign opv_below = opv_key < old_key;

    // Select the new word per action; unused codes behave as a load.
    always_comb
    begin
        result.next_word = old_word;
        result.ret_word  = old_word;
        result.xchg      = 1'b0;
        case (action)
            amu_pkg::ACT_STORE:
            begin
                result.next_word = operand_value;
                result.ret_word  = '0;
            end
            amu_pkg::ACT_ADD:  result.next_word = old_word + operand_value;
            amu_pkg::ACT_SUB:  result.next_word = old_word - operand_value;
            amu_pkg::ACT_MAX:  result.next_word = old_below ? operand_value : old_word;
            amu_pkg::ACT_MIN:  result.next_word = opv_below ? operand_value : old_word;
            amu_pkg::ACT_AND:  result.next_word = old_word & operand_value;
            amu_pkg::ACT_OR:   result.next_word = old_word | operand_value;
            amu_pkg::ACT_XOR:  result.next_word = old_word ^ operand_value;
            amu_pkg::ACT_XCHG: result.next_word = operand_value;
            amu_pkg::ACT_CMPXCHG:
            begin
                if (old_word == compare_value)
                begin
                    result.next_word = operand_value;
                    result.xchg      = 1'b1;
                end
            end
            default:
            begin
                result.next_word = old_word;
            end
        endcase
    end

endmodule

// File: sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking testbench of the atomic memory unit
// Drives atomic requests and APB size writes into atomic_memory_unit. A
// scoreboard keeps its own copy of the word memory, predicts the old value,
// the exchange flag and the bounds flag of every accepted request, and
// checks each result in order. The run sweeps several memory sizes and
// several idle and stall patterns on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    // Action codes outside the defined set, which act as plain loads.
    localparam logic [3:0]                 ACT_UNUSED_LO = 4'd11;
    localparam logic [3:0]                 ACT_UNUSED_HI = 4'd15;
    localparam logic [amu_pkg::WORD_W-1:0] ALL_ONES      = '1;
    localparam logic [amu_pkg::WORD_W-1:0] SIGN_BIT      = 32'h8000_0000;
    localparam logic [amu_pkg::WORD_W-1:0] TOP_POSITIVE  = 32'h7FFF_FFFF;
    localparam logic [amu_pkg::SIZE_W-1:0] SIZE_NONE     = '0;
    localparam logic [amu_pkg::SIZE_W-1:0] SIZE_MAX      = '1;
    localparam int                         LAST_WORD     = amu_pkg::DEPTH - 1;
    localparam int                         HOT_WORDS     = 8;
    localparam int                         SETTLE_CYCLES = 8;
    localparam int                         MAX_REPORTS   = 10;
    localparam longint                     TIMEOUT_NS    = 64'd3_000_000;

    // Expected outcome of one request.
    typedef struct {
        logic [amu_pkg::WORD_W-1:0] old_word;
        logic                       xchg;
        logic                       oob;
    } amu_result_t;

    // Scoreboard: shadow memory, size register and the queue of results due.
    class amu_scoreboard;
        logic [amu_pkg::WORD_W-1:0] mem_words [amu_pkg::DEPTH];
        logic [amu_pkg::SIZE_W-1:0] size_in_use;
        amu_result_t                results_due [$];
        int                         requests;
        int                         checked;
        int                         mismatches;
        int                         oob_count;
        int                         xchg_count;

        function new();
            foreach (mem_words[i])
            begin
                mem_words[i] = '0;
            end
            size_in_use = amu_pkg::WORDS_RESET;
            requests    = 0;
            checked     = 0;
            mismatches  = 0;
            oob_count   = 0;
            xchg_count  = 0;
        endfunction

        function logic [amu_pkg::WORD_W-1:0] word_at(logic [amu_pkg::INDEX_W-1:0] idx);
            return mem_words[idx];
        endfunction

        // Ordering for max and min; signed ordering compares as signed numbers.
        function bit ordered_below(logic [amu_pkg::WORD_W-1:0] a,
                                   logic [amu_pkg::WORD_W-1:0] b, logic sgn);
            if (sgn)
                return $signed(a) < $signed(b);
            return a < b;
        endfunction

        // Apply one accepted request to the shadow memory and queue its result.
        function void note_request(logic [3:0] act, logic sgn,
                                   logic [amu_pkg::INDEX_W-1:0] idx,
                                   logic [amu_pkg::WORD_W-1:0] opv,
                                   logic [amu_pkg::WORD_W-1:0] cmpv);
            amu_result_t                res;
            logic [amu_pkg::WORD_W-1:0] old_word;
            logic [amu_pkg::WORD_W-1:0] next_word;
            res.old_word = '0;
            res.xchg     = 1'b0;
            res.oob      = 1'b0;
            requests++;
            if (idx >= size_in_use || idx >= amu_pkg::DEPTH)
            begin
                res.oob = 1'b1;
                oob_count++;
            end
            else
            begin
                old_word     = mem_words[idx];
                next_word    = old_word;
                res.old_word = old_word;
                case (act)
                    amu_pkg::ACT_STORE:
                    begin
                        next_word    = opv;
                        res.old_word = '0;
                    end
                    amu_pkg::ACT_ADD:  next_word = old_word + opv;
                    amu_pkg::ACT_SUB:  next_word = old_word - opv;
                    amu_pkg::ACT_MAX:  if (ordered_below(old_word, opv, sgn)) next_word = opv;
                    amu_pkg::ACT_MIN:  if (ordered_below(opv, old_word, sgn)) next_word = opv;
                    amu_pkg::ACT_AND:  next_word = old_word & opv;
                    amu_pkg::ACT_OR:   next_word = old_word | opv;
                    amu_pkg::ACT_XOR:  next_word = old_word ^ opv;
                    amu_pkg::ACT_XCHG: next_word = opv;
                    amu_pkg::ACT_CMPXCHG:
                    begin
                        if (old_word == cmpv)
                        begin
                            next_word = opv;
                            res.xchg  = 1'b1;
                            xchg_count++;
                        end
                    end
                    default: next_word = old_word;
                endcase
                mem_words[idx] = next_word;
            end
            results_due.push_back(res);
        endfunction

        function void report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        // Compare one result transaction with the oldest expectation.
        function void check_result(logic [amu_pkg::WORD_W-1:0] old_word, logic xchg,
                                   logic oob);
            amu_result_t want;
            if (results_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result prior_value=%h exchanged=%b oob=%b",
                                          old_word, xchg, oob));
                return;
            end
            want = results_due.pop_front();
            checked++;
            if (old_word !== want.old_word || xchg !== want.xchg || oob !== want.oob)
                report_mismatch($sformatf(
                    "result %0d: prior_value %h/%h exchanged %b/%b oob %b/%b (expected/actual)",
                    checked, want.old_word, old_word, want.xchg, xchg, want.oob, oob));
        endfunction
    endclass

    // Block signals; every input starts at a known value.
    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [amu_pkg::PADDR_W-1:0]   paddr         = '0;
    logic [31:0]                   pwdata        = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          in_valid      = 1'b0;
    logic                          in_stall;
    logic [3:0]                    action        = '0;
    logic                          is_signed     = 1'b0;
    logic [amu_pkg::INDEX_W-1:0]   word_index    = '0;
    logic [amu_pkg::WORD_W-1:0]    operand_value = '0;
    logic [amu_pkg::WORD_W-1:0]    compare_value = '0;
    logic                          out_valid;
    logic                          out_stall     = 1'b0;
    logic [amu_pkg::WORD_W-1:0]    prior_value;
    logic                          exchanged;
    logic                          out_of_bounds;

    amu_scoreboard                 amu_sb = new();
    int                            idle_pct      = 0;
    int                            stall_pct     = 0;
    int                            size_settings = 0;
    logic [amu_pkg::INDEX_W-1:0]   last_index    = '0;

    atomic_memory_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .is_signed     (is_signed),
        .word_index    (word_index),
        .operand_value (operand_value),
        .compare_value (compare_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .prior_value   (prior_value),
        .exchanged     (exchanged),
        .out_of_bounds (out_of_bounds)
    );

    // Clock generation.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout: %0d results still due", amu_sb.results_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: stall at random with the current phase's probability.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            amu_sb.check_result(prior_value, exchanged, out_of_bounds);
    end

    // Send one request transaction and wait for it to be taken.
    task automatic send_request(logic [3:0] act, logic sgn, logic [amu_pkg::INDEX_W-1:0] idx,
                                logic [amu_pkg::WORD_W-1:0] opv,
                                logic [amu_pkg::WORD_W-1:0] cmpv);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        is_signed     <= sgn;
        word_index    <= idx;
        operand_value <= opv;
        compare_value <= cmpv;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        amu_sb.note_request(act, sgn, idx, opv, cmpv);
        last_index = idx;
    endtask

    // Hold off the sender until every due result has come back.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (amu_sb.results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of the size register: setup cycle, then access cycle.
    task automatic write_words_in_use(logic [amu_pkg::SIZE_W-1:0] words);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= amu_pkg::ADDR_WORDS_IN_USE;
        pwdata  <= 32'(words);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        amu_sb.size_in_use = words;
        size_settings++;
    endtask

    function automatic logic [amu_pkg::WORD_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return SIGN_BIT;
            3:       return TOP_POSITIVE;
            4:       return 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // One random request, mostly aimed at a few hot words so that
    // read-modify-write chains and back-to-back accesses build up.
    task automatic send_random_request();
        logic [3:0]                  act;
        logic [amu_pkg::INDEX_W-1:0] idx;
        logic [amu_pkg::WORD_W-1:0]  opv;
        logic [amu_pkg::WORD_W-1:0]  cmpv;
        int                          pick;
        if ($urandom_range(0, 99) < 88)
            act = 4'($urandom_range(amu_pkg::ACT_LOAD, amu_pkg::ACT_CMPXCHG));
        else
            act = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        pick = $urandom_range(0, 99);
        if (pick < 55)
            idx = amu_pkg::INDEX_W'($urandom_range(0, HOT_WORDS - 1));
        else if (pick < 70)
            idx = last_index;
        else
            idx = amu_pkg::INDEX_W'($urandom_range(0, LAST_WORD));
        opv = pick_operand();
        if (act == amu_pkg::ACT_CMPXCHG && $urandom_range(0, 99) < 60)
            cmpv = amu_sb.word_at(idx);
        else
            cmpv = pick_operand();
        send_request(act, 1'($urandom_range(0, 1)), idx, opv, cmpv);
    endtask

    // One phase: new size, new idle and stall patterns, a run of random requests.
    task automatic run_phase(logic [amu_pkg::SIZE_W-1:0] words, int idle, int stall, int count,
                             bit pause_midway);
        wait_until_idle();
        write_words_in_use(words);
        idle_pct  = idle;
        stall_pct = stall;
        for (int k = 0; k < count; k++)
        begin
            if (pause_midway && k == count / 2)
                wait_until_idle();
            send_random_request();
        end
    endtask

    // Main sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_words_in_use(amu_pkg::SIZE_W'(amu_pkg::DEPTH));

        // Directed checks on the first and last words, back to back.
        send_request(amu_pkg::ACT_LOAD,    1'b0, '0, '0, '0);
        send_request(amu_pkg::ACT_STORE,   1'b0, '0, ALL_ONES, '0);
        send_request(amu_pkg::ACT_ADD,     1'b0, '0, 32'd1, '0);
        send_request(amu_pkg::ACT_SUB,     1'b0, '0, 32'd1, '0);
        send_request(amu_pkg::ACT_MAX,     1'b1, '0, 32'd1, '0);
        send_request(amu_pkg::ACT_MAX,     1'b0, '0, SIGN_BIT, '0);
        send_request(amu_pkg::ACT_MIN,     1'b1, '0, TOP_POSITIVE, '0);
        send_request(amu_pkg::ACT_MIN,     1'b0, '0, TOP_POSITIVE, '0);
        send_request(amu_pkg::ACT_AND,     1'b0, '0, 32'h0F0F_0F0F, '0);
        send_request(amu_pkg::ACT_OR,      1'b0, '0, 32'hA0A0_A0A0, '0);
        send_request(amu_pkg::ACT_XOR,     1'b0, '0, ALL_ONES, '0);
        send_request(amu_pkg::ACT_XCHG,    1'b0, '0, 32'h1234_5678, '0);
        send_request(amu_pkg::ACT_CMPXCHG, 1'b0, '0, 32'hDEAD_BEEF, 32'h1234_5678);
        send_request(amu_pkg::ACT_CMPXCHG, 1'b0, '0, '0, 32'h1234_5678);
        send_request(amu_pkg::ACT_STORE,   1'b1, amu_pkg::INDEX_W'(LAST_WORD), ALL_ONES,
                     ALL_ONES);
        send_request(amu_pkg::ACT_LOAD,    1'b0, amu_pkg::INDEX_W'(LAST_WORD), '0, '0);
        for (int code = ACT_UNUSED_LO; code <= ACT_UNUSED_HI; code++)
            send_request(4'(code), 1'b1, amu_pkg::INDEX_W'(LAST_WORD), '0, ALL_ONES);

        // The last word falls out of bounds once the size drops by one.
        wait_until_idle();
        write_words_in_use(amu_pkg::SIZE_W'(LAST_WORD));
        send_request(amu_pkg::ACT_STORE, 1'b0, amu_pkg::INDEX_W'(LAST_WORD), 32'h5555_AAAA,
                     '0);
        send_request(amu_pkg::ACT_LOAD,  1'b0, amu_pkg::INDEX_W'(LAST_WORD), '0, '0);

        run_phase(amu_pkg::SIZE_W'(amu_pkg::DEPTH), 0,  0,  150, 1'b1);
        run_phase(SIZE_MAX,                         69, 0,  130, 1'b0);
        run_phase(SIZE_NONE,                        0,  69, 40,  1'b0);
        run_phase(amu_pkg::SIZE_W'(LAST_WORD),      22, 22, 140, 1'b0);
        run_phase(amu_pkg::SIZE_W'(16),             0,  69, 120, 1'b0);
        run_phase(amu_pkg::SIZE_W'(1),              22, 22, 60,  1'b0);
        run_phase(amu_pkg::SIZE_W'($urandom_range(2, LAST_WORD)), 69, 0, 80, 1'b0);
        run_phase(amu_pkg::SIZE_W'(amu_pkg::DEPTH), 0,  0,  60,  1'b0);
        wait_until_idle();

        $display("Run covered %0d requests over %0d size settings and %0d checked results,",
                 amu_sb.requests, size_settings, amu_sb.checked);
        $display("with %0d out-of-bounds requests, %0d compare-exchange writes, %0d mismatches.",
                 amu_sb.oob_count, amu_sb.xchg_count, amu_sb.mismatches);
        if (amu_sb.mismatches == 0 && amu_sb.results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
